@@ rtl/smac_pkg.sv @@
// shared types and constants for the shadow memory access checker
// no dependencies; used by smac_gran_alu and shadow_memory_access_checker
`default_nettype none

package smac_pkg;

  localparam int SHADOW_DEPTH_DEF = 4096;
  localparam int ADDR_W = 48;
  localparam int SIZE_W = 16;

  // item kinds
  localparam logic [2:0] KIND_CHK_RD      = 3'd0;
  localparam logic [2:0] KIND_CHK_WR      = 3'd1;
  localparam logic [2:0] KIND_UNPOISON    = 3'd2;
  localparam logic [2:0] KIND_PSN_FREED   = 3'd3;
  localparam logic [2:0] KIND_PSN_REDZONE = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_WINDOW_BASE  = 2'd0;
  localparam logic [1:0] CFG_FREED_CODE   = 2'd1;
  localparam logic [1:0] CFG_REDZONE_CODE = 2'd2;

  localparam logic [7:0] FREED_CODE_RST   = 8'hFF;
  localparam logic [7:0] REDZONE_CODE_RST = 8'hFE;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_UAF          = 3'd1,
    ST_REDZONE      = 3'd2,
    ST_POISON       = 3'd3,
    ST_PARTIAL      = 3'd4,
    ST_OUTSIDE      = 3'd5,
    ST_INCONSISTENT = 3'd6,
    ST_UNALIGNED    = 3'd7
  } status_t;

  // operations of the granule unit
  typedef enum logic [2:0] {
    GOP_CHECK,
    GOP_UNALIGNED,
    GOP_PSN_SINGLE,
    GOP_PSN_HEAD,
    GOP_PSN_TAIL,
    GOP_UNP_TAIL
  } gop_t;

  typedef struct packed {
    logic       fail;
    status_t    status;
    logic       we;
    logic [7:0] wval;
  } gran_res_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIFF,
    S_RANGE,
    S_CHK,
    S_UNAL,
    S_SGL,
    S_HEAD,
    S_FILL,
    S_TAIL,
    S_FIN
  } seq_state_t;

endpackage

`default_nettype wire

@@ rtl/smac_gran_alu.sv @@
// granule unit: judges one shadow byte for a check or computes its new value for a mark
// depends on smac_pkg
`default_nettype none

module smac_gran_alu (
  input  var smac_pkg::gop_t      op,
  input  var logic [7:0]          shadow,
  input  var logic [2:0]          ofs,
  input  var logic [3:0]          len,
  input  var logic [2:0]          left,
  input  var logic [7:0]          code,
  input  var logic [7:0]          freed,
  input  var logic [7:0]          redzone,
  output smac_pkg::gran_res_t     res
);

  logic                neg;
  logic                pos;
  logic [3:0]          reach;
  smac_pkg::status_t   cls;

  assign neg   = shadow[7];
  assign pos   = !shadow[7] && (shadow != 8'd0);
  assign reach = {1'b0, ofs} + len;

  always_comb begin
    if (neg) begin
      if (shadow == freed) cls = smac_pkg::ST_UAF;
      else if (shadow == redzone) cls = smac_pkg::ST_REDZONE;
      else cls = smac_pkg::ST_POISON;
    end else begin
      cls = smac_pkg::ST_PARTIAL;
    end
  end

  always_comb begin
    res.fail   = 1'b0;
    res.status = smac_pkg::ST_OK;
    res.we     = 1'b0;
    res.wval   = code;
    case (op)
      smac_pkg::GOP_CHECK: begin
        res.fail   = neg || (pos && ({4'd0, reach} > shadow));
        res.status = cls;
      end
      smac_pkg::GOP_UNALIGNED: begin
        res.fail   = 1'b1;
        res.status = smac_pkg::ST_UNALIGNED;
      end
      smac_pkg::GOP_PSN_SINGLE: begin
        if (pos) begin
          if ({4'd0, reach} == shadow) begin
            res.we   = 1'b1;
            res.wval = (ofs == 3'd0) ? code : {5'd0, ofs};
          end else begin
            res.fail   = 1'b1;
            res.status = smac_pkg::ST_INCONSISTENT;
          end
        end
      end
      smac_pkg::GOP_PSN_HEAD: begin
        // shrink the accessible prefix down to the offset
        res.we   = (shadow == 8'd0) || (pos && ({5'd0, ofs} < shadow));
        res.wval = {5'd0, ofs};
      end
      smac_pkg::GOP_PSN_TAIL: begin
        res.we = pos && (shadow == {5'd0, left});
      end
      smac_pkg::GOP_UNP_TAIL: begin
        res.we   = neg || (pos && ({5'd0, left} > shadow));
        res.wval = {5'd0, left};
      end
      default: begin
        res.fail = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/shadow_memory_access_checker.sv @@
// shadow memory access checker top level: sequencer, shadow store, window check
// depends on smac_pkg and smac_gran_alu
//
//   channel | direction | transfer when        | payload
//   in      | input     | in_valid & in_ready   | in_kind, in_address, in_size
//   out     | output    | out_valid & out_ready | out_status, out_fault_address,
//           |           |                       | out_shadow_value, out_was_write
//   cfg     | input     | cfg_we                | cfg_index, cfg_wdata
//
// an item is set up and checked against the window in S_DIFF and S_RANGE, then
// walks each granule touched or written (one shadow read or write a cycle), plus
// a fetch of its tail granule for a range mark, then S_FIN hands the result to
// the output register
// after reset a clearing pass zeroes the shadow store,
// during which in_ready stays low; config writes are taken at any time
// a new item may be accepted while the previous result waits on out_ready
`default_nettype none

module shadow_memory_access_checker #(
  parameter int SHADOW_DEPTH = smac_pkg::SHADOW_DEPTH_DEF
) (
  input  var logic                         clk,
  input  var logic                         rst_n,
  input  var logic                         in_valid,
  output logic                             in_ready,
  input  var logic [2:0]                   in_kind,
  input  var logic [smac_pkg::ADDR_W-1:0]  in_address,
  input  var logic [smac_pkg::SIZE_W-1:0]  in_size,
  output logic                             out_valid,
  input  var logic                         out_ready,
  output logic [2:0]                       out_status,
  output logic [smac_pkg::ADDR_W-1:0]      out_fault_address,
  output logic signed [7:0]                out_shadow_value,
  output logic                             out_was_write,
  input  var logic                         cfg_we,
  input  var logic [1:0]                   cfg_index,
  input  var logic [smac_pkg::ADDR_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(SHADOW_DEPTH);
  localparam int DW = smac_pkg::ADDR_W + 1;
  localparam logic [DW-1:0] LIM = DW'(8 * SHADOW_DEPTH);
  localparam logic [AW-1:0] LAST_ENTRY = AW'(SHADOW_DEPTH - 1);

  // shadow store
  logic [7:0] shadow_mem [SHADOW_DEPTH];
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      shadow_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= shadow_mem[mem_raddr];
  end

  // control and payload registers
  smac_pkg::seq_state_t state_r, state_nxt;
  logic [AW-1:0]                  clr_cnt_r, clr_cnt_nxt;
  logic [smac_pkg::ADDR_W-1:0]    base_r;
  logic [7:0]                     freed_r;
  logic [7:0]                     redzone_r;
  logic [2:0]                     kind_r, kind_nxt;
  logic [smac_pkg::ADDR_W-1:0]    addr_r, addr_nxt;
  logic [smac_pkg::SIZE_W-1:0]    size_r, size_nxt;
  logic [DW-1:0]                  offs_r, offs_nxt;
  logic [smac_pkg::ADDR_W-1:0]    a_r, a_nxt;
  logic [smac_pkg::SIZE_W-1:0]    rem_r, rem_nxt;
  logic [AW:0]                    g_r, g_nxt;
  logic [AW:0]                    e_r, e_nxt;
  logic [2:0]                     res_status_r, res_status_nxt;
  logic [smac_pkg::ADDR_W-1:0]    res_addr_r, res_addr_nxt;
  logic [7:0]                     res_val_r, res_val_nxt;
  logic                           res_wr_r, res_wr_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [2:0]                     out_status_r, out_status_nxt;
  logic [smac_pkg::ADDR_W-1:0]    out_addr_r, out_addr_nxt;
  logic [7:0]                     out_val_r, out_val_nxt;
  logic                           out_wr_r, out_wr_nxt;

  // shared combinational terms
  logic                 accept;
  logic                 out_free;
  logic [DW-1:0]        end_c;
  logic                 oob;
  logic [AW-1:0]        s_c;
  logic [AW:0]          e_c;
  logic [2:0]           off_c;
  logic [2:0]           left_c;
  logic [3:0]           room_c;
  logic [3:0]           t_c;
  logic                 last_c;
  logic [7:0]           code_c;
  logic [7:0]           fill_c;

  assign in_ready = (state_r == smac_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign end_c  = {1'b0, offs_r[smac_pkg::ADDR_W-1:0]} + DW'(size_r);
  assign oob    = offs_r[DW-1] || ({1'b0, offs_r[smac_pkg::ADDR_W-1:0]} >= LIM) ||
                  (end_c > LIM);
  assign s_c    = offs_r[AW+2:3];
  assign e_c    = end_c[AW+3:3];
  assign off_c  = addr_r[2:0];
  assign left_c = addr_r[2:0] + size_r[2:0];

  // bytes of the access inside the current granule
  assign room_c = 4'd8 - {1'b0, a_r[2:0]};
  assign t_c    = ({12'd0, room_c} > rem_r) ? rem_r[3:0] : room_c;
  assign last_c = (rem_r == {12'd0, t_c});

  assign code_c = (kind_r == smac_pkg::KIND_PSN_FREED) ? freed_r : redzone_r;
  assign fill_c = (kind_r == smac_pkg::KIND_UNPOISON) ? 8'd0 : code_c;

  // granule unit
  smac_pkg::gop_t      gop;
  logic [2:0]          gofs;
  logic [3:0]          glen;
  smac_pkg::gran_res_t gres;

  always_comb begin
    gop  = smac_pkg::GOP_CHECK;
    gofs = a_r[2:0];
    glen = t_c;
    case (state_r)
      smac_pkg::S_UNAL: begin
        gop = smac_pkg::GOP_UNALIGNED;
      end
      smac_pkg::S_SGL: begin
        gop  = smac_pkg::GOP_PSN_SINGLE;
        gofs = off_c;
        glen = size_r[3:0];
      end
      smac_pkg::S_HEAD: begin
        gop  = smac_pkg::GOP_PSN_HEAD;
        gofs = off_c;
      end
      smac_pkg::S_TAIL: begin
        gop = (kind_r == smac_pkg::KIND_UNPOISON) ? smac_pkg::GOP_UNP_TAIL
                                                  : smac_pkg::GOP_PSN_TAIL;
      end
      default: begin
        gop = smac_pkg::GOP_CHECK;
      end
    endcase
  end

  smac_gran_alu u_gran_alu (
    .op      (gop),
    .shadow  (rdata_r),
    .ofs     (gofs),
    .len     (glen),
    .left    (left_c),
    .code    (code_c),
    .freed   (freed_r),
    .redzone (redzone_r),
    .res     (gres)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smac_pkg::S_CLEAR: begin
        if (clr_cnt_r == LAST_ENTRY) state_nxt = smac_pkg::S_IDLE;
      end
      smac_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = (in_kind > smac_pkg::KIND_PSN_REDZONE) ? smac_pkg::S_FIN
                                                             : smac_pkg::S_DIFF;
        end
      end
      smac_pkg::S_DIFF: begin
        state_nxt = smac_pkg::S_RANGE;
      end
      smac_pkg::S_RANGE: begin
        if (oob) begin
          state_nxt = smac_pkg::S_FIN;
        end else begin
          case (kind_r)
            smac_pkg::KIND_CHK_RD, smac_pkg::KIND_CHK_WR: begin
              state_nxt = (size_r == '0) ? smac_pkg::S_FIN : smac_pkg::S_CHK;
            end
            smac_pkg::KIND_UNPOISON: begin
              state_nxt = (off_c != 3'd0) ? smac_pkg::S_UNAL : smac_pkg::S_FILL;
            end
            smac_pkg::KIND_PSN_FREED, smac_pkg::KIND_PSN_REDZONE: begin
              if ({1'b0, s_c} == e_c) state_nxt = smac_pkg::S_SGL;
              else if (off_c != 3'd0) state_nxt = smac_pkg::S_HEAD;
              else state_nxt = smac_pkg::S_FILL;
            end
            default: begin
              state_nxt = smac_pkg::S_FIN;
            end
          endcase
        end
      end
      smac_pkg::S_CHK: begin
        if (gres.fail || last_c) state_nxt = smac_pkg::S_FIN;
      end
      smac_pkg::S_HEAD: begin
        state_nxt = smac_pkg::S_FILL;
      end
      smac_pkg::S_FILL: begin
        if (g_r == e_r) begin
          state_nxt = (left_c != 3'd0) ? smac_pkg::S_TAIL : smac_pkg::S_FIN;
        end
      end
      smac_pkg::S_UNAL, smac_pkg::S_SGL, smac_pkg::S_TAIL: begin
        state_nxt = smac_pkg::S_FIN;
      end
      smac_pkg::S_FIN: begin
        if (out_free) state_nxt = smac_pkg::S_IDLE;
      end
      default: begin
        state_nxt = smac_pkg::S_CLEAR;
      end
    endcase
  end

  // datapath and shadow store control
  always_comb begin
    clr_cnt_nxt    = clr_cnt_r;
    kind_nxt       = kind_r;
    addr_nxt       = addr_r;
    size_nxt       = size_r;
    offs_nxt       = offs_r;
    a_nxt          = a_r;
    rem_nxt        = rem_r;
    g_nxt          = g_r;
    e_nxt          = e_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_val_nxt    = res_val_r;
    res_wr_nxt     = res_wr_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_val_nxt    = out_val_r;
    out_wr_nxt     = out_wr_r;
    mem_we         = 1'b0;
    mem_waddr      = g_r[AW-1:0];
    mem_wdata      = gres.wval;
    mem_raddr      = g_r[AW-1:0];
    case (state_r)
      smac_pkg::S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = 8'd0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
      end
      smac_pkg::S_IDLE: begin
        if (accept) begin
          kind_nxt       = in_kind;
          addr_nxt       = in_address;
          size_nxt       = in_size;
          res_status_nxt = smac_pkg::ST_OK;
          res_addr_nxt   = in_address;
          res_val_nxt    = 8'd0;
          res_wr_nxt     = 1'b0;
        end
      end
      smac_pkg::S_DIFF: begin
        offs_nxt = {1'b0, addr_r} - {1'b0, base_r};
      end
      smac_pkg::S_RANGE: begin
        mem_raddr      = s_c;
        g_nxt          = {1'b0, s_c};
        e_nxt          = e_c;
        a_nxt          = addr_r;
        rem_nxt        = size_r;
        res_status_nxt = oob ? smac_pkg::ST_OUTSIDE : smac_pkg::ST_OK;
        res_addr_nxt   = addr_r;
        res_val_nxt    = 8'd0;
        res_wr_nxt     = (kind_r == smac_pkg::KIND_CHK_WR);
      end
      smac_pkg::S_CHK: begin
        if (gres.fail) begin
          res_status_nxt = gres.status;
          res_addr_nxt   = a_r;
          res_val_nxt    = rdata_r;
        end else if (!last_c) begin
          // advance to the next granule and fetch its shadow byte
          a_nxt     = a_r + smac_pkg::ADDR_W'(t_c);
          rem_nxt   = rem_r - smac_pkg::SIZE_W'(t_c);
          g_nxt     = g_r + (AW+1)'(1);
          mem_raddr = g_r[AW-1:0] + AW'(1);
        end
      end
      smac_pkg::S_UNAL: begin
        res_status_nxt = gres.status;
        res_val_nxt    = rdata_r;
      end
      smac_pkg::S_SGL: begin
        mem_we = gres.we;
        if (gres.fail) begin
          res_status_nxt = gres.status;
          res_val_nxt    = rdata_r;
        end
      end
      smac_pkg::S_HEAD: begin
        mem_we = gres.we;
        g_nxt  = g_r + (AW+1)'(1);
      end
      smac_pkg::S_FILL: begin
        if (g_r != e_r) begin
          mem_we    = 1'b1;
          mem_wdata = fill_c;
          g_nxt     = g_r + (AW+1)'(1);
        end else begin
          mem_raddr = e_r[AW-1:0];
        end
      end
      smac_pkg::S_TAIL: begin
        mem_we    = gres.we;
        mem_waddr = e_r[AW-1:0];
      end
      smac_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          out_val_nxt    = res_val_r;
          out_wr_nxt     = res_wr_r;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smac_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      freed_r   <= smac_pkg::FREED_CODE_RST;
      redzone_r <= smac_pkg::REDZONE_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        smac_pkg::CFG_WINDOW_BASE:  base_r    <= {cfg_wdata[smac_pkg::ADDR_W-1:3], 3'd0};
        smac_pkg::CFG_FREED_CODE:   freed_r   <= cfg_wdata[7:0];
        smac_pkg::CFG_REDZONE_CODE: redzone_r <= cfg_wdata[7:0];
        default: begin
          base_r <= base_r;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    addr_r       <= addr_nxt;
    size_r       <= size_nxt;
    offs_r       <= offs_nxt;
    a_r          <= a_nxt;
    rem_r        <= rem_nxt;
    g_r          <= g_nxt;
    e_r          <= e_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_val_r    <= res_val_nxt;
    res_wr_r     <= res_wr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_val_r    <= out_val_nxt;
    out_wr_r     <= out_wr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_fault_address = out_addr_r;
  assign out_shadow_value  = out_val_r;
  assign out_was_write     = out_wr_r;

`ifndef SYNTHESIS
  // no item taken while the clearing pass runs
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == smac_pkg::S_CLEAR |-> !in_ready)
    else $error("input accepted during shadow clear");

  // fill pointer never runs past the end granule
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == smac_pkg::S_FILL |-> g_r <= e_r)
    else $error("fill pointer past end granule");

  // the walk only runs with bytes left
  a_chk_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == smac_pkg::S_CHK |-> rem_r != '0)
    else $error("granule walk with no bytes left");

  // a waiting result is never overwritten
  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == smac_pkg::S_FIN && out_valid_r && !out_ready |=>
      state_r == smac_pkg::S_FIN && out_valid_r)
    else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

@@ tb/tb_shadow_memory_access_checker.sv @@
// self-checking testbench for shadow_memory_access_checker
// depends on smac_pkg and the rtl top level; holds its own model of the shadow store
`timescale 1ns / 1ps

module tb_shadow_memory_access_checker;

  localparam int DEPTH = smac_pkg::SHADOW_DEPTH_DEF;
  localparam logic [63:0] WINDOW_BYTES = 64'(DEPTH) * 64'd8;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int IDLE_PAD = 4;
  localparam int TAIL_CYCLES = 32;
  localparam int NUM_PHASES = 6;
  localparam int NUM_ROWS = 28;

  // kinds the block ignores
  localparam logic [2:0] KIND_RSVD_5 = 3'd5;
  localparam logic [2:0] KIND_RSVD_7 = 3'd7;

  typedef struct packed {
    smac_pkg::status_t status;
    logic [47:0]       fault;
    logic [7:0]        sval;
    logic              wr;
  } verdict_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] addr;
    logic [15:0] size;
  } stim_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         what;
    logic [2:0]        kind;
    logic [1:0]        ridx;
    logic [47:0]       addr;   // register data on a config row
    logic [15:0]       size;
    bit                typed;
    smac_pkg::status_t st;
    logic [47:0]       fault;
    logic [7:0]        sv;
    logic              wr;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_kind = 3'd0;
  logic [47:0] in_address = 48'd0;
  logic [15:0] in_size = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [47:0] out_fault_address;
  logic signed [7:0] out_shadow_value;
  logic        out_was_write;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [47:0] cfg_wdata = 48'd0;

  shadow_memory_access_checker u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_address       (in_address),
    .in_size          (in_size),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_fault_address(out_fault_address),
    .out_shadow_value (out_shadow_value),
    .out_was_write    (out_was_write),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model state
  logic [7:0]  shadow_mem [DEPTH];
  logic [63:0] win_base = 64'd0;
  logic [7:0]  code_freed = smac_pkg::FREED_CODE_RST;
  logic [7:0]  code_redzone = smac_pkg::REDZONE_CODE_RST;

  verdict_t pending_verdicts [$];
  stim_t    stimulus [$];
  bit       calm = 1'b0;
  int       errors = 0;
  int       items_sent = 0;
  int       ignored_sent = 0;
  int       cfg_writes = 0;
  int       results_checked = 0;
  int       status_hits [8];

  initial begin
    foreach (shadow_mem[i]) shadow_mem[i] = 8'd0;
    foreach (status_hits[i]) status_hits[i] = 0;
  end

  row_t directed_rows [NUM_ROWS] = '{
    '{ROW_ITEM, smac_pkg::KIND_CHK_RD, 2'd0, 48'd0, 16'd8, 1,
      smac_pkg::ST_OK, 48'd0, 8'h00, 1'b0},
    '{ROW_ITEM, smac_pkg::KIND_CHK_WR, 2'd0, 48'd0, 16'd0, 1,
      smac_pkg::ST_OK, 48'd0, 8'h00, 1'b1},
    '{ROW_ITEM, smac_pkg::KIND_CHK_RD, 2'd0, 48'd32768, 16'd1, 1,
      smac_pkg::ST_OUTSIDE, 48'd32768, 8'h00, 1'b0},
    '{ROW_ITEM, smac_pkg::KIND_CHK_WR, 2'd0, 48'd32760, 16'd9, 1,
      smac_pkg::ST_OUTSIDE, 48'd32760, 8'h00, 1'b1},
    '{ROW_ITEM, smac_pkg::KIND_CHK_RD, 2'd0, 48'hFFFF_FFFF_FFFF, 16'd32768, 1,
      smac_pkg::ST_OUTSIDE, 48'hFFFF_FFFF_FFFF, 8'h00, 1'b0},
    '{ROW_ITEM, smac_pkg::KIND_CHK_WR, 2'd0, 48'd0, 16'd32768, 1,
      smac_pkg::ST_OK, 48'd0, 8'h00, 1'b1},
    '{ROW_ITEM, KIND_RSVD_5, 2'd0, 48'd123, 16'd7, 1,
      smac_pkg::ST_OK, 48'd123, 8'h00, 1'b0},
    '{ROW_ITEM, KIND_RSVD_7, 2'd0, 48'hFFFF_FFFF_FFFF, 16'h7FFF, 1,
      smac_pkg::ST_OK, 48'hFFFF_FFFF_FFFF, 8'h00, 1'b0},
    '{ROW_ITEM, smac_pkg::KIND_PSN_FREED, 2'd0, 48'd64, 16'd16, 1,
      smac_pkg::ST_OK, 48'd64, 8'h00, 1'b0},
    '{ROW_ITEM, smac_pkg::KIND_CHK_RD, 2'd0, 48'd64, 16'd1, 1,
      smac_pkg::ST_UAF, 48'd64, 8'hFF, 1'b0},
    '{ROW_ITEM, smac_pkg::KIND_CHK_WR, 2'd0, 48'd70, 16'd4, 1,
      smac_pkg::ST_UAF, 48'd70, 8'hFF, 1'b1},
    '{ROW_ITEM, smac_pkg::KIND_PSN_REDZONE, 2'd0, 48'd128, 16'd8, 1,
      smac_pkg::ST_OK, 48'd128, 8'h00, 1'b0},
    '{ROW_ITEM, smac_pkg::KIND_CHK_RD, 2'd0, 48'd124, 16'd8, 1,
      smac_pkg::ST_REDZONE, 48'd128, 8'hFE, 1'b0},
    '{ROW_ITEM, smac_pkg::KIND_UNPOISON, 2'd0, 48'd64, 16'd13, 1,
      smac_pkg::ST_OK, 48'd64, 8'h00, 1'b0},
    '{ROW_ITEM, smac_pkg::KIND_CHK_RD, 2'd0, 48'd72, 16'd5, 0,
      smac_pkg::ST_OK, 48'd0, 8'h00, 1'b0},
    '{ROW_ITEM, smac_pkg::KIND_CHK_RD, 2'd0, 48'd72, 16'd6, 1,
      smac_pkg::ST_PARTIAL, 48'd72, 8'h05, 1'b0},
    '{ROW_ITEM, smac_pkg::KIND_UNPOISON, 2'd0, 48'd129, 16'd3, 1,
      smac_pkg::ST_UNALIGNED, 48'd129, 8'hFE, 1'b0},
    '{ROW_ITEM, smac_pkg::KIND_PSN_FREED, 2'd0, 48'd74, 16'd3, 0,
      smac_pkg::ST_OK, 48'd0, 8'h00, 1'b0},
    '{ROW_ITEM, smac_pkg::KIND_PSN_REDZONE, 2'd0, 48'd72, 16'd1, 1,
      smac_pkg::ST_INCONSISTENT, 48'd72, 8'h02, 1'b0},
    '{ROW_ITEM, smac_pkg::KIND_PSN_REDZONE, 2'd0, 48'd72, 16'd2, 0,
      smac_pkg::ST_OK, 48'd0, 8'h00, 1'b0},
    '{ROW_ITEM, smac_pkg::KIND_PSN_FREED, 2'd0, 48'd83, 16'd20, 0,
      smac_pkg::ST_OK, 48'd0, 8'h00, 1'b0},
    '{ROW_ITEM, smac_pkg::KIND_CHK_RD, 2'd0, 48'd80, 16'd16, 0,
      smac_pkg::ST_OK, 48'd0, 8'h00, 1'b0},
    '{ROW_CFG, smac_pkg::KIND_CHK_RD, smac_pkg::CFG_FREED_CODE, 48'h80, 16'd0, 0,
      smac_pkg::ST_OK, 48'd0, 8'h00, 1'b0},
    '{ROW_ITEM, smac_pkg::KIND_CHK_RD, 2'd0, 48'd88, 16'd1, 1,
      smac_pkg::ST_POISON, 48'd88, 8'hFF, 1'b0},
    '{ROW_CFG, smac_pkg::KIND_CHK_RD, smac_pkg::CFG_WINDOW_BASE, 48'h1_0000_0007, 16'd0, 0,
      smac_pkg::ST_OK, 48'd0, 8'h00, 1'b0},
    '{ROW_ITEM, smac_pkg::KIND_CHK_RD, 2'd0, 48'd0, 16'd1, 1,
      smac_pkg::ST_OUTSIDE, 48'd0, 8'h00, 1'b0},
    '{ROW_ITEM, smac_pkg::KIND_CHK_RD, 2'd0, 48'h1_0000_0048, 16'd4, 0,
      smac_pkg::ST_OK, 48'd0, 8'h00, 1'b0},
    '{ROW_ITEM, smac_pkg::KIND_UNPOISON, 2'd0, 48'h1_0000_0048, 16'd13, 0,
      smac_pkg::ST_OK, 48'd0, 8'h00, 1'b0}
  };

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic smac_pkg::status_t poison_class(input logic [7:0] b);
    if (!b[7]) return smac_pkg::ST_PARTIAL;
    if (b == code_freed) return smac_pkg::ST_UAF;
    if (b == code_redzone) return smac_pkg::ST_REDZONE;
    return smac_pkg::ST_POISON;
  endfunction

  // expected result of one item; updates the model's shadow store
  function automatic verdict_t access_outcome(input logic [2:0] kind, input logic [47:0] addr,
                                              input logic [15:0] size);
    verdict_t    v;
    logic [63:0] a64, end64, a, rem, n, t, s, e, g;
    logic [7:0]  b, code, off, left;
    a64 = {16'd0, addr};
    end64 = a64 + {48'd0, size};
    v.status = smac_pkg::ST_OK;
    v.fault = addr;
    v.sval = 8'd0;
    v.wr = 1'b0;
    if (kind > smac_pkg::KIND_PSN_REDZONE) return v;
    v.wr = (kind == smac_pkg::KIND_CHK_WR);
    if (a64 < win_base || a64 - win_base >= WINDOW_BYTES || end64 - win_base > WINDOW_BYTES)
    begin
      v.status = smac_pkg::ST_OUTSIDE;
      return v;
    end
    s = (a64 - win_base) >> 3;
    e = (end64 - win_base) >> 3;
    off = {5'd0, addr[2:0]};
    left = {5'd0, end64[2:0]};

    if (kind == smac_pkg::KIND_CHK_RD || kind == smac_pkg::KIND_CHK_WR) begin
      a = a64;
      rem = {48'd0, size};
      while (rem != 0) begin
        g = (a - win_base) >> 3;
        n = a & 64'd7;
        t = (rem < 64'd8 - n) ? rem : 64'd8 - n;
        b = shadow_mem[g];
        if (b != 8'd0 && (b[7] || n + t > {56'd0, b})) begin
          v.status = poison_class(b);
          v.fault = a[47:0];
          v.sval = b;
          return v;
        end
        a = a + t;
        rem = rem - t;
      end
      return v;
    end

    if (kind == smac_pkg::KIND_UNPOISON) begin
      if (off != 8'd0) begin
        v.status = smac_pkg::ST_UNALIGNED;
        v.sval = shadow_mem[s];
        return v;
      end
      for (g = s; g < e; g++) shadow_mem[g] = 8'd0;
      if (left != 8'd0) begin
        b = shadow_mem[e];
        if (b[7]) shadow_mem[e] = left;
        else if (b != 8'd0 && left > b) shadow_mem[e] = left;
      end
      return v;
    end

    code = (kind == smac_pkg::KIND_PSN_FREED) ? code_freed : code_redzone;
    if (s == e) begin
      b = shadow_mem[s];
      if (!b[7] && b != 8'd0) begin
        if ({56'd0, off} + {48'd0, size} == {56'd0, b}) begin
          shadow_mem[s] = (off == 8'd0) ? code : off;
        end else begin
          v.status = smac_pkg::ST_INCONSISTENT;
          v.sval = b;
        end
      end
      return v;
    end
    g = s;
    // partial head granule keeps what lies below the start
    if (off != 8'd0) begin
      b = shadow_mem[g];
      if (b == 8'd0) shadow_mem[g] = off;
      else if (!b[7] && off < b) shadow_mem[g] = off;
      g++;
    end
    for (; g < e; g++) shadow_mem[g] = code;
    if (left != 8'd0) begin
      b = shadow_mem[e];
      if (!b[7] && b == left) shadow_mem[e] = code;
    end
    return v;
  endfunction

  task automatic issue(input logic [2:0] kind, input logic [47:0] addr,
                       input logic [15:0] size, output verdict_t pred);
    if (!calm && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(99) < 35);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_address <= addr;
    in_size <= size;
    do @(posedge clk); while (!in_ready);
    pred = access_outcome(kind, addr, size);
    if (kind <= smac_pkg::KIND_PSN_REDZONE) items_sent++;
    else ignored_sent++;
  endtask

  // register writes only once every result is back
  task automatic cfg_write(input logic [1:0] idx, input logic [47:0] data);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (IDLE_PAD) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    case (idx)
      smac_pkg::CFG_WINDOW_BASE:  win_base = {16'd0, data & ~48'h7};
      smac_pkg::CFG_FREED_CODE:   code_freed = data[7:0];
      smac_pkg::CFG_REDZONE_CODE: code_redzone = data[7:0];
      default: ;
    endcase
  endtask

  task automatic report(input string field, input logic [47:0] want, input logic [47:0] got);
    errors++;
    $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
  endtask

  // result side: random backpressure and in-order compare
  always @(posedge clk) begin : result_check
    verdict_t want;
    out_ready <= calm || ($urandom_range(99) >= 35);
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      status_hits[out_status]++;
      if (pending_verdicts.size() == 0) begin
        report("unexpected result, status", 48'd0, {45'd0, out_status});
      end else begin
        want = pending_verdicts.pop_front();
        if (out_status !== want.status)
          report("status", {45'd0, want.status}, {45'd0, out_status});
        if (out_fault_address !== want.fault)
          report("fault_address", want.fault, out_fault_address);
        if (out_shadow_value !== want.sval)
          report("shadow_value", {40'd0, want.sval}, {40'd0, out_shadow_value});
        if (out_was_write !== want.wr)
          report("was_write", {47'd0, want.wr}, {47'd0, out_was_write});
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("shadow_memory_access_checker: mismatch");
    $finish;
  end

  initial begin : stim
    verdict_t    pred;
    stim_t       st;
    logic [47:0] hot_base, p;
    logic [15:0] n, sz;
    int          r, ph, quota, taken, rnd;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].what == ROW_CFG) begin
        cfg_write(directed_rows[r].ridx, directed_rows[r].addr);
      end else begin
        issue(directed_rows[r].kind, directed_rows[r].addr, directed_rows[r].size, pred);
        if (directed_rows[r].typed) begin
          pred.status = directed_rows[r].st;
          pred.fault = directed_rows[r].fault;
          pred.sval = directed_rows[r].sv;
          pred.wr = directed_rows[r].wr;
        end
        pending_verdicts.push_back(pred);
      end
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          cfg_write(smac_pkg::CFG_WINDOW_BASE, 48'h3);
          cfg_write(smac_pkg::CFG_FREED_CODE, {rand48() & ~48'hFF} | 48'hFF);
          cfg_write(smac_pkg::CFG_REDZONE_CODE, 48'hFE);
          quota = 400;
        end
        1: begin
          cfg_write(smac_pkg::CFG_WINDOW_BASE, 48'hFFFF_FFFF_8000);
          cfg_write(smac_pkg::CFG_FREED_CODE, 48'h80);
          cfg_write(smac_pkg::CFG_REDZONE_CODE, 48'hFF);
          quota = 400;
        end
        2: begin
          cfg_write(smac_pkg::CFG_WINDOW_BASE, rand48());
          cfg_write(smac_pkg::CFG_FREED_CODE, {rand48()} | 48'h80);
          cfg_write(smac_pkg::CFG_REDZONE_CODE, {rand48()} | 48'h80);
          quota = 400;
        end
        3: begin
          cfg_write(smac_pkg::CFG_WINDOW_BASE, 48'hFFFF_FFFF_FFFF);
          cfg_write(smac_pkg::CFG_FREED_CODE, 48'h81);
          cfg_write(smac_pkg::CFG_REDZONE_CODE, 48'h80);
          quota = 100;
        end
        4: begin
          // same code for both poisons
          cfg_write(smac_pkg::CFG_WINDOW_BASE, 48'h5555_5555_5555);
          cfg_write(smac_pkg::CFG_FREED_CODE, 48'hC0);
          cfg_write(smac_pkg::CFG_REDZONE_CODE, 48'hC0);
          quota = 300;
        end
        default: begin
          cfg_write(smac_pkg::CFG_WINDOW_BASE, 48'hAAAA_AAAA_AAA8);
          cfg_write(smac_pkg::CFG_FREED_CODE, {rand48()} | 48'h80);
          cfg_write(smac_pkg::CFG_REDZONE_CODE, {rand48()} | 48'h80);
          quota = 300;
        end
      endcase
      hot_base = win_base[47:0] + 48'(8 * $urandom_range(0, DEPTH - 300));
      stimulus.delete();
      taken = 0;
      while (taken < quota) begin
        if (ph == NUM_PHASES - 1 && taken == quota / 3 && !calm) begin
          // hold off until the block has drained, then run without idling
          in_valid <= 1'b0;
          while (pending_verdicts.size() != 0) @(posedge clk);
          @(posedge clk);
          calm = 1'b1;
        end
        if (ph == NUM_PHASES - 1 && taken == quota * 5 / 6) calm = 1'b0;
        if (stimulus.size() == 0) begin
          if ($urandom_range(99) < 65) begin
            // object lifetime: unpoison, redzone after it, probe, free, probe
            p = hot_base + 48'(8 * $urandom_range(0, 240));
            n = 16'($urandom_range(1, 40));
            stimulus.push_back('{smac_pkg::KIND_UNPOISON, p, n});
            stimulus.push_back('{smac_pkg::KIND_PSN_REDZONE, p + 48'(n),
                                 16'($urandom_range(1, 24))});
            repeat (3) stimulus.push_back('{($urandom_range(1) ? smac_pkg::KIND_CHK_WR
                                                                : smac_pkg::KIND_CHK_RD),
                                            p - 48'd8 + 48'($urandom_range(0, n + 16)),
                                            16'($urandom_range(1, 16))});
            sz = ($urandom_range(3) == 0) ? ((n + 16'd7) & ~16'd7) : n;
            stimulus.push_back('{smac_pkg::KIND_PSN_FREED, p, sz});
            repeat (2) stimulus.push_back('{($urandom_range(1) ? smac_pkg::KIND_CHK_WR
                                                                : smac_pkg::KIND_CHK_RD),
                                            p + 48'($urandom_range(0, n)),
                                            16'($urandom_range(0, 16))});
          end else begin
            st.kind = 3'($urandom_range(0, 7));
            rnd = $urandom_range(99);
            if (rnd < 70) st.addr = hot_base + 48'($urandom_range(0, 2047));
            else if (rnd < 85) st.addr = win_base[47:0] + 48'($urandom_range(0, DEPTH * 8 - 1));
            else if (rnd < 93) st.addr = win_base[47:0] + 48'(DEPTH * 8 - $urandom_range(0, 16));
            else if (rnd < 96) st.addr = win_base[47:0] - 48'($urandom_range(1, 16));
            else st.addr = rand48();
            rnd = $urandom_range(99);
            if (rnd < 88) st.size = 16'($urandom_range(0, 24));
            else if (rnd < 98) st.size = 16'($urandom_range(25, 400));
            else st.size = 16'($urandom_range(401, 32768));
            stimulus.push_back(st);
          end
        end
        st = stimulus.pop_front();
        issue(st.kind, st.addr, st.size, pred);
        pending_verdicts.push_back(pred);
        if (st.kind <= smac_pkg::KIND_PSN_REDZONE) taken++;
      end
    end

    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d items (plus %0d of unused kinds), %0d register writes, %0d results checked",
             items_sent, ignored_sent, cfg_writes, results_checked);
    $display("by status: ok %0d uaf %0d redzone %0d poison %0d partial %0d outside %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4],
             status_hits[5]);
    $display("           inconsistent %0d unaligned %0d", status_hits[6], status_hits[7]);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("shadow_memory_access_checker: match");
    end else begin
      $display("shadow_memory_access_checker: mismatch");
    end
    $finish;
  end

endmodule
